FILE: design/rle565_pkg.sv
// ----------------------------------------------------------------------------
// rle565_pkg
// Shared constants, result beat type and color packing for the RGB565
// run-length encoder.
// ----------------------------------------------------------------------------
package rle565_pkg;

    localparam int COUNT_BITS = 16;
    localparam int LEN_BITS   = 16;
    localparam int COLOR_BITS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] RUN_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [LEN_BITS-1:0]   run_length;
        logic [COLOR_BITS-1:0] packed_color;
        logic                  end_of_image;
    } result_t;

    function automatic logic [COLOR_BITS-1:0] pack565(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [LEN_BITS-1:0] count_to_len(
        input logic [COUNT_BITS-1:0] count
    );
        logic [COUNT_BITS+LEN_BITS-1:0] wide;
        wide = {{LEN_BITS{1'b0}}, count};
        count_to_len = wide[LEN_BITS-1:0];
    endfunction

endpackage

FILE: design/rgb565_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// rgb565_run_length_encoder_top
// Packs 8-bit RGB pixels to RGB565 and emits raw pixels or run-length pairs.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while in_ready is high. Packing and run
// tracking complete in the cycle of acceptance; the pixel's results (none,
// one, or two when a run closes on the last pixel) land in a four-beat result
// queue that feeds the output. in_ready depends only on queue occupancy: it is
// high while at least two entries are free, so with one or fewer results per
// pixel and a ready sink the block sustains one pixel per clock. Output beats
// leave at most one per clock; a second result waits behind the first. If the
// queue was empty, the first result beat appears the cycle after its pixel.
module rgb565_run_length_encoder_top
    import rle565_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] run_length,
    output logic [15:0] packed_color,
    output logic        end_of_image
);

    logic                  rle_enable_reg;
    logic [COLOR_BITS-1:0] run_color_reg;
    logic [COLOR_BITS-1:0] run_color_next;
    logic [COUNT_BITS-1:0] run_count_reg;
    logic [COUNT_BITS-1:0] run_count_next;
    logic                  run_open_reg;
    logic                  run_open_next;

    result_t               fifo_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   wr_ptr_plus1;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   fifo_count_reg;
    logic [CNT_BITS-1:0]   fifo_count_next;

    logic                  in_fire;
    logic                  out_fire;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  emit_run;
    logic                  wr_first;
    logic                  wr_second;
    result_t               first_beat;
    result_t               second_beat;
    result_t               flush_beat;
    result_t               head_beat;

    assign in_fire      = in_valid && in_ready;
    assign out_fire     = out_valid && out_ready;
    assign in_ready     = fifo_count_reg <= CNT_BITS'(FIFO_DEPTH - 2);
    assign out_valid    = fifo_count_reg != '0;
    assign pixel_color  = pack565(red, green, blue);
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);

    always_comb
    begin
        emit_run       = 1'b0;
        run_open_next  = run_open_reg;
        run_count_next = run_count_reg;
        run_color_next = run_color_reg;
        first_beat     = '0;
        second_beat    = '0;
        flush_beat     = '0;
        wr_first       = 1'b0;
        wr_second      = 1'b0;

        if (in_fire) begin
            if (!rle_enable_reg) begin
                first_beat = '{run_length: LEN_BITS'(1), packed_color: pixel_color,
                               end_of_image: last_pixel};
                wr_first   = 1'b1;
                if (last_pixel) begin
                    run_open_next  = 1'b0;
                    run_count_next = '0;
                end
            end else begin
                emit_run = run_open_reg &&
                           ((run_color_reg != pixel_color) || (run_count_reg == RUN_MAX));
                if (!run_open_reg || emit_run) begin
                    run_count_next = COUNT_BITS'(1);
                    run_color_next = pixel_color;
                end else begin
                    run_count_next = run_count_reg + COUNT_BITS'(1);
                end
                run_open_next = 1'b1;
                flush_beat = '{run_length: count_to_len(run_count_next),
                               packed_color: run_color_next, end_of_image: 1'b1};
                if (emit_run) begin
                    first_beat  = '{run_length: count_to_len(run_count_reg),
                                    packed_color: run_color_reg, end_of_image: 1'b0};
                    wr_first    = 1'b1;
                    second_beat = flush_beat;
                    wr_second   = last_pixel;
                end else begin
                    first_beat = flush_beat;
                    wr_first   = last_pixel;
                end
                if (last_pixel) begin
                    run_open_next  = 1'b0;
                    run_count_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg + PTR_BITS'({1'b0, wr_first} + {1'b0, wr_second});
        rd_ptr_next     = rd_ptr_reg + PTR_BITS'(out_fire);
        fifo_count_next = fifo_count_reg + CNT_BITS'(wr_first) + CNT_BITS'(wr_second)
                          - CNT_BITS'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rle_enable_reg <= 1'b1;
            run_color_reg  <= '0;
            run_count_reg  <= '0;
            run_open_reg   <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (cfg_write_enable) begin
                rle_enable_reg <= cfg_write_data;
            end
            run_color_reg  <= run_color_next;
            run_count_reg  <= run_count_next;
            run_open_reg   <= run_open_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_first) begin
            fifo_mem[wr_ptr_reg] <= first_beat;
        end
        if (wr_second) begin
            fifo_mem[wr_ptr_plus1] <= second_beat;
        end
    end

    assign head_beat    = fifo_mem[rd_ptr_reg];
    assign run_length   = head_beat.run_length;
    assign packed_color = head_beat.packed_color;
    assign end_of_image = head_beat.end_of_image;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= CNT_BITS'(FIFO_DEPTH))
        else $error("result queue over capacity");

    a_open_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> (run_count_reg != '0))
        else $error("open run with zero count");

    a_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_pixel) |=> (!run_open_reg && (run_count_reg == '0)))
        else $error("run not closed after last pixel");

    a_raw_keeps_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !rle_enable_reg && !last_pixel)
            |=> ($stable(run_open_reg) && $stable(run_count_reg)))
        else $error("raw pixel disturbed run state");

    a_fifo_track: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_fire) |=> (fifo_count_reg >= $past(fifo_count_reg)))
        else $error("queue count dropped without a read");
`endif

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB565 run-length encoder. Pixels are sent
// through directed image sequences and a long random stream of images in
// both raw and run-length modes. An in-bench encoder predicts each run beat,
// and every output beat is checked in order against it while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import rle565_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_enable;
    logic        cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] run_length;
    logic [15:0] packed_color;
    logic        end_of_image;

    result_t                runs_due[$];
    bit                     mode_rle;
    logic [COLOR_BITS-1:0]  held_color;
    logic [COUNT_BITS-1:0]  held_count;
    bit                     held_open;

    int          mismatches;
    int          cycle_count;
    logic [11:0] sink_cycle;
    int          burst_left;

    rgb565_run_length_encoder_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .last_pixel       (last_pixel),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .run_length       (run_length),
        .packed_color     (packed_color),
        .end_of_image     (end_of_image)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_run(input logic [COUNT_BITS-1:0] count,
                                     input logic [COLOR_BITS-1:0] color,
                                     input logic eoi);
        result_t beat;
        beat.run_length   = count[LEN_BITS-1:0];
        beat.packed_color = color;
        beat.end_of_image = eoi;
        runs_due.push_back(beat);
    endfunction

    function automatic void encode_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic last);
        logic [COLOR_BITS-1:0] color;
        color = {r[7:3], g[7:2], b[7:3]};
        if (!mode_rle)
        begin
            push_run(COUNT_BITS'(1), color, last);
            if (last)
            begin
                held_open  = 1'b0;
                held_count = '0;
            end
            return;
        end
        if (!held_open)
        begin
            held_open  = 1'b1;
            held_count = COUNT_BITS'(1);
            held_color = color;
        end
        else if (held_color != color || held_count == RUN_MAX)
        begin
            push_run(held_count, held_color, 1'b0);
            held_count = COUNT_BITS'(1);
            held_color = color;
        end
        else
        begin
            held_count = held_count + 1'b1;
        end
        if (last)
        begin
            push_run(held_count, held_color, 1'b1);
            held_open  = 1'b0;
            held_count = '0;
        end
    endfunction

    // hold each beat until taken; insert random gaps between bursts
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid   <= 1'b1;
        red        <= r;
        green      <= g;
        blue       <= b;
        last_pixel <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        encode_pixel(r, g, b, last);
    endtask

    task automatic wait_for_runs();
        in_valid <= 1'b0;
        while (runs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rle_enable(input bit on);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= on;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        mode_rle = on;
    endtask

    task automatic test_run_basics();
        write_rle_enable(1'b1);
        send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
        send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
        send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
        send_pixel(8'h80, 8'h40, 8'h20, 1'b0);
        send_pixel(8'h80, 8'h40, 8'h20, 1'b0);
        send_pixel(8'hF0, 8'h0C, 8'h48, 1'b1);
        send_pixel(8'h33, 8'h66, 8'h99, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h07, 8'h03, 8'h07, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        wait_for_runs();
    endtask

    task automatic test_raw_mid_run();
        send_pixel(8'h48, 8'h90, 8'hC8, 1'b0);
        send_pixel(8'h48, 8'h90, 8'hC8, 1'b0);
        wait_for_runs();
        write_rle_enable(1'b0);
        send_pixel(8'h11, 8'h22, 8'h33, 1'b0);
        wait_for_runs();
        write_rle_enable(1'b1);
        send_pixel(8'h48, 8'h90, 8'hC8, 1'b1);
        send_pixel(8'h48, 8'h90, 8'hC8, 1'b0);
        send_pixel(8'h48, 8'h90, 8'hC8, 1'b0);
        wait_for_runs();
        write_rle_enable(1'b0);
        send_pixel(8'hE0, 8'h1C, 8'h03, 1'b1);
        wait_for_runs();
        write_rle_enable(1'b1);
        send_pixel(8'h48, 8'h90, 8'hC8, 1'b1);
        wait_for_runs();
    endtask

    task automatic test_raw_extremes();
        write_rle_enable(1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hF8, 8'hFC, 8'hF8, 1'b0);
        send_pixel(8'h07, 8'h03, 8'h07, 1'b1);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b1);
        wait_for_runs();
    endtask

    task automatic test_random_images();
        int         sent;
        int         len;
        int         k;
        bit         last;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        sent = 0;
        while (sent < 1200)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_for_runs();
                write_rle_enable(1'($urandom_range(0, 1)));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 20);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            for (k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: ;
                    4, 5:
                    begin
                        r[2:0] = 3'($urandom);
                        g[1:0] = 2'($urandom);
                        b[2:0] = 3'($urandom);
                    end
                    default:
                    begin
                        r = 8'($urandom);
                        g = 8'($urandom);
                        b = 8'($urandom);
                    end
                endcase
                if (k > 0 && $urandom_range(0, 60) == 0)
                begin
                    wait_for_runs();
                    write_rle_enable(1'($urandom_range(0, 1)));
                end
                last = (k == len - 1) && ($urandom_range(0, 7) != 0);
                send_pixel(r, g, b, last);
                sent++;
            end
        end
        wait_for_runs();
    endtask

    // stall on a pattern that rotates through four phases
    always @(posedge clk)
    begin
        sink_cycle <= sink_cycle + 1'b1;
        case (sink_cycle[10:9])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 1) == 1);
            2'd2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= sink_cycle[2];
        endcase
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (runs_due.size() == 0)
            begin
                $display("%0t: unexpected beat run_length %0d packed_color %h eoi %b",
                         $time, run_length, packed_color, end_of_image);
                mismatches++;
            end
            else
            begin
                want = runs_due.pop_front();
                if (run_length !== want.run_length)
                begin
                    $display("%0t: run_length expected %0d actual %0d",
                             $time, want.run_length, run_length);
                    mismatches++;
                end
                if (packed_color !== want.packed_color)
                begin
                    $display("%0t: packed_color expected %h actual %h",
                             $time, want.packed_color, packed_color);
                    mismatches++;
                end
                if (end_of_image !== want.end_of_image)
                begin
                    $display("%0t: end_of_image expected %b actual %b",
                             $time, want.end_of_image, end_of_image);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d beats outstanding", $time, runs_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = 1'b0;
        in_valid         = 1'b0;
        red              = '0;
        green            = '0;
        blue             = '0;
        last_pixel       = 1'b0;
        out_ready        = 1'b0;
        sink_cycle       = '0;
        cycle_count      = 0;
        mismatches       = 0;
        burst_left       = 0;
        mode_rle         = 1'b1;
        held_color       = '0;
        held_count       = '0;
        held_open        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_run_basics();
        test_raw_mid_run();
        test_raw_extremes();
        test_random_images();

        if (runs_due.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, runs_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
